>>> rtl/streaming_top_k_by_count_core_defines.svh
// Assertion macros for the top-K selection core.
// Included by files that carry concurrent checks; needs clock and reset in scope.
`ifndef STREAMING_TOP_K_BY_COUNT_CORE_DEFINES_SVH
`define STREAMING_TOP_K_BY_COUNT_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define STKC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define STKC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/stkc_pkg.sv
// Shared types and constants for the top-K selection core.
// No dependencies; used by the interfaces, the cell and the top level.
package stkc_pkg;

   localparam int KEY_FIELD_W = 48;
   localparam int COUNT_W     = 32;
   localparam int CFG_W       = 6;

   typedef logic [KEY_FIELD_W-1:0] key_field_type;
   typedef logic [COUNT_W-1:0]     count_type;
   typedef logic [CFG_W-1:0]       cfg_type;
   typedef logic [1:0]             cmd_type;

   localparam cmd_type CMD_OFFER = 2'd0;
   localparam cmd_type CMD_DRAIN = 2'd1;
   localparam cmd_type CMD_CLEAR = 2'd2;

   localparam cfg_type KEEP_COUNT_RST = 6'd32;

   // Per-cycle action applied to every cell of the chain.
   typedef enum logic [1:0] {
      OP_HOLD    = 2'd0,
      OP_INSERT  = 2'd1,
      OP_REPLACE = 2'd2,
      OP_SHIFT   = 2'd3
   } cell_op_type;

   // Flags a cell hands to its right neighbor.
   typedef struct packed {
      logic ge;       // valid and count >= offered count
      logic min_grp;  // valid and count equals the current minimum
   } link_type;

endpackage

>>> rtl/stkc_req_if.sv
// Request channel: command plus offered entry, valid/ready handshake.
// Depends on stkc_pkg.
interface stkc_req_if;
   import stkc_pkg::*;

   logic          valid;
   logic          ready;
   cmd_type       cmd;
   key_field_type entry_key;
   count_type     entry_count;

   modport source (output valid, cmd, entry_key, entry_count, input ready);
   modport sink   (input valid, cmd, entry_key, entry_count, output ready);
endinterface

>>> rtl/stkc_rsp_if.sv
// Response channel: drained entries, valid/ready handshake.
// Depends on stkc_pkg.
interface stkc_rsp_if;
   import stkc_pkg::*;

   logic          valid;
   logic          ready;
   key_field_type out_key;
   count_type     out_count;
   logic          out_last;

   modport source (output valid, out_key, out_count, out_last, input ready);
   modport sink   (input valid, out_key, out_count, out_last, output ready);
endinterface

>>> rtl/stkc_cell.sv
// One slot of the sorted chain: holds a key and count, shifts with its neighbors.
// Depends on stkc_pkg.
module stkc_cell #(
   parameter int IDX   = 0,
   parameter int KEY_W = 48,
   parameter int OCC_W = 6
) (
   input  logic                  clock,
   input  stkc_pkg::cell_op_type op,
   input  logic [OCC_W-1:0]      occupancy,
   input  stkc_pkg::count_type   min_count,
   input  logic [KEY_W-1:0]      new_key,
   input  stkc_pkg::count_type   new_count,
   input  stkc_pkg::link_type    left_link,
   input  logic [KEY_W-1:0]      left_key,
   input  stkc_pkg::count_type   left_count,
   input  logic [KEY_W-1:0]      right_key,
   input  stkc_pkg::count_type   right_count,
   output stkc_pkg::link_type    link,
   output logic [KEY_W-1:0]      key,
   output stkc_pkg::count_type   count
);
   import stkc_pkg::*;

   localparam logic [OCC_W-1:0] IDX_V = OCC_W'(IDX);

   logic [KEY_W-1:0] key_ff, key_in;
   count_type        count_ff, count_in;
   logic             valid;
   logic             ins_here;
   logic             take_left;

   assign valid        = IDX_V < occupancy;
   assign link.ge      = valid && (count_ff >= new_count);
   assign link.min_grp = valid && (count_ff == min_count);

   // Insertion point: first slot not ge, right after one that is.
   assign ins_here  = !link.ge && left_link.ge;
   assign take_left = !left_link.ge;

   always_comb begin
      key_in   = key_ff;
      count_in = count_ff;
      case (op)
         OP_INSERT: begin
            if (ins_here) begin
               key_in   = new_key;
               count_in = new_count;
            end else if (take_left) begin
               key_in   = left_key;
               count_in = left_count;
            end
         end
         OP_REPLACE: begin
            // slots past the evicted entry keep their contents
            if (ins_here) begin
               key_in   = new_key;
               count_in = new_count;
            end else if (take_left && !left_link.min_grp) begin
               key_in   = left_key;
               count_in = left_count;
            end
         end
         OP_SHIFT: begin
            key_in   = right_key;
            count_in = right_count;
         end
         default: begin
            key_in   = key_ff;
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      count_ff <= count_in;
   end

   assign key   = key_ff;
   assign count = count_ff;

endmodule

>>> rtl/streaming_top_k_by_count_core.sv
// Top level of the streaming top-K selection core: control, occupancy, output register.
// Depends on stkc_pkg, stkc_req_if, stkc_rsp_if, stkc_cell and the defines header.
//
//   channel    | dir | handshake        | payload
//   -----------+-----+------------------+----------------------------------
//   req_chan   | in  | valid/ready      | cmd, entry_key, entry_count
//   rsp_chan   | out | valid/ready      | out_key, out_count, out_last
//   csr_*      | in  | write enable     | csr_wdata = keep_count
//
// Offer and clear requests are taken while no drain is running; ready then stays high,
// so they stream at one per cycle. A drain holds the request side until every kept entry
// has been loaded, the chain shifting one slot toward the output register per transfer.
// Synchronous active-high reset empties the chain (occupancy zero) and sets
// keep_count to 32. A stalled response freezes the chain; the last drained entry
// sits in the output register while new requests are already taken.
module streaming_top_k_by_count_core #(
   parameter int STORE_DEPTH = 32,
   parameter int KEY_BYTES   = 6
) (
   input  logic              clock,
   input  logic              reset,
   stkc_req_if.sink          req_chan,
   stkc_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  stkc_pkg::cfg_type csr_wdata
);
   import stkc_pkg::*;

`include "streaming_top_k_by_count_core_defines.svh"

   localparam int KEY_W = (8 * KEY_BYTES < KEY_FIELD_W) ? 8 * KEY_BYTES : KEY_FIELD_W;
   localparam int OCC_W = $clog2(STORE_DEPTH + 1);
   localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CW    = (OCC_W > CFG_W) ? OCC_W : CFG_W;
   localparam logic [CW-1:0]    DEPTH_C   = CW'(STORE_DEPTH);
   localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(STORE_DEPTH);
   localparam logic [OCC_W-1:0] OCC_ONE   = OCC_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   cfg_type          keep_ff, keep_in;

   logic             rsp_valid_ff, rsp_valid_in;
   key_field_type    rsp_key_ff, rsp_key_in;
   count_type        rsp_count_ff, rsp_count_in;
   logic             rsp_last_ff, rsp_last_in;

   // chain wiring
   logic [KEY_W-1:0] cell_key   [STORE_DEPTH];
   count_type        cell_count [STORE_DEPTH];
   link_type         cell_link  [STORE_DEPTH];
   cell_op_type      op;

   logic [CW-1:0]    lim;
   logic [CW-1:0]    keep_ext;
   logic [CW-1:0]    occ_ext;
   logic [IDX_W-1:0] last_idx;
   count_type        min_count;
   logic             req_fire;
   logic             do_insert;
   logic             do_replace;
   logic             load;

   assign keep_ext = CW'(keep_ff);
   assign occ_ext  = CW'(occ_ff);
   assign lim      = (keep_ext > DEPTH_C) ? DEPTH_C : keep_ext;

   // tail of the chain holds the newest entry of the minimum count group
   assign last_idx  = IDX_W'(occ_ff - OCC_ONE);
   assign min_count = cell_count[last_idx];

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign do_insert  = req_fire && (req_chan.cmd == CMD_OFFER) && (occ_ext < lim);
   assign do_replace = req_fire && (req_chan.cmd == CMD_OFFER) && (lim != '0)
                       && (occ_ext >= lim) && (occ_ff != '0)
                       && (req_chan.entry_count > min_count);

   // during a drain, the output register refills whenever empty or its transfer completes
   assign load = (state_ff == ST_DRAIN) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      if (do_insert) begin
         op = OP_INSERT;
      end else if (do_replace) begin
         op = OP_REPLACE;
      end else if (load) begin
         op = OP_SHIFT;
      end else begin
         op = OP_HOLD;
      end
   end

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      keep_in      = csr_we ? csr_wdata : keep_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.cmd)
                  CMD_OFFER: begin
                     if (do_insert) begin
                        occ_in = occ_ff + OCC_ONE;
                     end
                  end
                  CMD_DRAIN: begin
                     if (occ_ff != '0) begin
                        state_in = ST_DRAIN;
                     end
                  end
                  CMD_CLEAR: begin
                     occ_in = '0;
                  end
                  default: begin
                     occ_in = occ_ff;
                  end
               endcase
            end
         end
         ST_DRAIN: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_key_in   = key_field_type'(cell_key[0]);
               rsp_count_in = cell_count[0];
               rsp_last_in  = (occ_ff == OCC_ONE);
               occ_in       = occ_ff - OCC_ONE;
               if (occ_ff == OCC_ONE) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         keep_ff      <= KEEP_COUNT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         keep_ff      <= keep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_key_ff   <= rsp_key_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_key   = rsp_key_ff;
   assign rsp_chan.out_count = rsp_count_ff;
   assign rsp_chan.out_last  = rsp_last_ff;

   // Sorted chain: slot 0 holds the largest count, ties oldest first.
   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      link_type         left_link;
      logic [KEY_W-1:0] left_key;
      count_type        left_count;
      logic [KEY_W-1:0] right_key;
      count_type        right_count;

      if (i == 0) begin : g_head
         // head sees a virtual neighbor that is always ge and never minimum
         assign left_link.ge      = 1'b1;
         assign left_link.min_grp = 1'b0;
         assign left_key          = cell_key[0];
         assign left_count        = cell_count[0];
      end else begin : g_body
         assign left_link  = cell_link[i-1];
         assign left_key   = cell_key[i-1];
         assign left_count = cell_count[i-1];
      end

      if (i == STORE_DEPTH - 1) begin : g_tail
         assign right_key   = cell_key[i];
         assign right_count = cell_count[i];
      end else begin : g_inner
         assign right_key   = cell_key[i+1];
         assign right_count = cell_count[i+1];
      end

      stkc_cell #(
         .IDX   (i),
         .KEY_W (KEY_W),
         .OCC_W (OCC_W)
      ) u_cell (
         .clock       (clock),
         .op          (op),
         .occupancy   (occ_ff),
         .min_count   (min_count),
         .new_key     (req_chan.entry_key[KEY_W-1:0]),
         .new_count   (req_chan.entry_count),
         .left_link   (left_link),
         .left_key    (left_key),
         .left_count  (left_count),
         .right_key   (right_key),
         .right_count (right_count),
         .link        (cell_link[i]),
         .key         (cell_key[i]),
         .count       (cell_count[i])
      );
   end

   // ---- checks ----
   `STKC_ASSERT_SAME(a_occ_bound, 1'b1, occ_ff <= DEPTH_OCC, "occupancy above store depth")
   `STKC_ASSERT_NEXT(a_occ_step, 1'b1, {1'b0, occ_ff} <= {1'b0, $past(occ_ff)} + 1'b1, "occupancy grew by more than one")
   `STKC_ASSERT_NEXT(a_drain_start, req_fire && (req_chan.cmd == CMD_DRAIN) && (occ_ff != '0), state_ff == ST_DRAIN, "drain not started")
   `STKC_ASSERT_NEXT(a_drain_end, load && (occ_ff == OCC_ONE), (state_ff == ST_IDLE) && (occ_ff == '0) && rsp_last_ff, "drain did not finish on last entry")

   if (STORE_DEPTH > 1) begin : g_order_chk
      `STKC_ASSERT_SAME(a_head_sorted, occ_ff >= OCC_W'(2), cell_count[0] >= cell_count[1], "chain head out of order")
   end

endmodule

>>> verif/stkc_top_k_checker.sv
// Checker for the streaming top-K core: watches request, response and csr ports,
// keeps its own ranked store and compares every drained entry in order.
// Depends on stkc_pkg, stkc_req_if and stkc_rsp_if.
module stkc_top_k_checker #(
   parameter int STORE_DEPTH = 32,
   parameter int KEY_BYTES   = 6
) (
   input  logic              clock,
   input  logic              reset,
   stkc_req_if               req_mon,
   stkc_rsp_if               rsp_mon,
   input  logic              csr_we,
   input  stkc_pkg::cfg_type csr_wdata,
   output int                error_count,
   output int                pending_results,
   output int                results_checked
);
   import stkc_pkg::*;

   localparam int KEY_KEEP_W = (8 * KEY_BYTES < KEY_FIELD_W) ? 8 * KEY_BYTES : KEY_FIELD_W;
   localparam key_field_type KEY_MASK =
      (KEY_KEEP_W == KEY_FIELD_W) ? '1 : ((key_field_type'(1) << KEY_KEEP_W) - 1);
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      key_field_type key;
      count_type     count;
      logic          last;
   } ranked_entry_type;

   // Ranked store: count descending, arrival ascending within equal counts.
   key_field_type rank_keys   [STORE_DEPTH];
   count_type     rank_counts [STORE_DEPTH];
   int            rank_fill;
   cfg_type       keep_limit;

   ranked_entry_type drain_expect_q[$];

   function automatic int limit_now();
      return (int'(keep_limit) > STORE_DEPTH) ? STORE_DEPTH : int'(keep_limit);
   endfunction

   // New entry goes behind every entry of equal or larger count.
   function automatic void rank_insert(key_field_type key, count_type cnt);
      int pos;
      pos = 0;
      while (pos < rank_fill && rank_counts[pos] >= cnt) pos++;
      for (int i = rank_fill; i > pos; i--) begin
         rank_keys[i]   = rank_keys[i-1];
         rank_counts[i] = rank_counts[i-1];
      end
      rank_keys[pos]   = key;
      rank_counts[pos] = cnt;
      rank_fill++;
   endfunction

   // Drop the oldest entry among those holding the minimum count.
   function automatic void evict_oldest_min();
      count_type min_cnt;
      int        pos;
      min_cnt = rank_counts[rank_fill-1];
      pos = 0;
      while (pos < rank_fill - 1 && rank_counts[pos] != min_cnt) pos++;
      for (int i = pos; i + 1 < rank_fill; i++) begin
         rank_keys[i]   = rank_keys[i+1];
         rank_counts[i] = rank_counts[i+1];
      end
      rank_fill--;
   endfunction

   function automatic void apply_request(cmd_type op, key_field_type key, count_type cnt);
      ranked_entry_type e;
      case (op)
         CMD_OFFER: begin
            if (limit_now() == 0) return;
            if (rank_fill < limit_now()) begin
               rank_insert(key & KEY_MASK, cnt);
            end else if (rank_fill > 0 && cnt > rank_counts[rank_fill-1]) begin
               evict_oldest_min();
               rank_insert(key & KEY_MASK, cnt);
            end
         end
         CMD_DRAIN: begin
            for (int i = 0; i < rank_fill; i++) begin
               e.key   = rank_keys[i];
               e.count = rank_counts[i];
               e.last  = (i == rank_fill - 1);
               drain_expect_q.push_back(e);
            end
            rank_fill = 0;
         end
         CMD_CLEAR: rank_fill = 0;
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      ranked_entry_type got, want;
      if (reset) begin
         rank_fill       = 0;
         keep_limit      = KEEP_COUNT_RST;
         error_count     = 0;
         results_checked = 0;
         drain_expect_q.delete();
      end else begin
         if (csr_we) keep_limit = csr_wdata;
         if (req_mon.valid && req_mon.ready)
            apply_request(req_mon.cmd, req_mon.entry_key, req_mon.entry_count);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.key   = rsp_mon.out_key;
            got.count = rsp_mon.out_count;
            got.last  = rsp_mon.out_last;
            results_checked++;
            if (drain_expect_q.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("unexpected transfer: key=%h count=%h last=%b",
                           got.key, got.count, got.last);
            end else begin
               want = drain_expect_q.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display({"mismatch: exp key=%h count=%h last=%b,",
                               " got key=%h count=%h last=%b"},
                              want.key, want.count, want.last,
                              got.key, got.count, got.last);
               end
            end
         end
      end
      pending_results = drain_expect_q.size();
   end

endmodule

>>> verif/streaming_top_k_by_count_core_tb.sv
// Testbench top for the streaming top-K core: clock, reset, stimulus and verdict.
// Depends on stkc_pkg, the channel interfaces, the core and stkc_top_k_checker.
module streaming_top_k_by_count_core_tb;
   import stkc_pkg::*;

   localparam int STORE_DEPTH  = 32;
   localparam int KEY_BYTES    = 6;
   localparam int RANDOM_ITEMS = 236;    // on top of the 24 directed requests
   localparam int SETTLE       = 8;      // cycles after the last result before a csr write
   localparam int LONG_HOLD    = 400;    // response hold-off, in cycles
   localparam int TAIL_CYCLES  = 40;
   localparam int DRAIN_LIMIT  = 20000;  // end-of-run wait for outstanding results
   localparam longint TIMEOUT  = 15_000_000;

   // The fourth command code has no name in the package; the core must ignore it.
   localparam cmd_type CMD_RESERVED = 2'd3;

   logic    clock;
   logic    reset;
   logic    csr_we;
   cfg_type csr_wdata;

   int chk_errors;
   int chk_pending;
   int chk_results;

   // Stimulus controls: request gaps, and response stalls shared with the response process
   bit send_gaps;
   bit rsp_stalls;
   int rsp_hold_len;

   int requests_sent;
   int drains_sent;
   int keep_writes;

   stkc_req_if req_chan ();
   stkc_rsp_if rsp_chan ();

   streaming_top_k_by_count_core #(
      .STORE_DEPTH (STORE_DEPTH),
      .KEY_BYTES   (KEY_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   stkc_top_k_checker #(
      .STORE_DEPTH (STORE_DEPTH),
      .KEY_BYTES   (KEY_BYTES)
   ) ranker_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .error_count     (chk_errors),
      .pending_results (chk_pending),
      .results_checked (chk_results)
   );

   // 12-unit clock period
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop in case a handshake never completes
   initial begin
      #(TIMEOUT);
      $display("run stopped: time limit reached, %0d results still outstanding", chk_pending);
      $display("*** FAILED ***");
      $finish;
   end

   // Response side. Ready changes only at the falling edge. A hold request from
   // the stimulus process parks ready low for a long, counted stretch so a drain
   // backs up into the request channel; otherwise short random stalls when enabled.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (rsp_hold_len) @(negedge clock);
            rsp_hold_len = 0;
            rsp_chan.ready <= 1'b1;
         end else if (rsp_stalls && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // One request transfer. Entered and left at a falling edge; valid stays high
   // on return so back-to-back requests stream without a bubble.
   task automatic push_request(input cmd_type op, input key_field_type key,
                               input count_type cnt);
      int gap;
      gap = 0;
      if (send_gaps && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.cmd         <= op;
      req_chan.entry_key   <= key;
      req_chan.entry_count <= cnt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      if (op != CMD_RESERVED) requests_sent++;
      if (op == CMD_DRAIN) drains_sent++;
   endtask

   // Sender pauses until every expected entry has come out, then lets the
   // output register and chain settle before anything else changes.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (chk_pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // keep_count write; only called while the core is idle
   task automatic write_keep(input cfg_type value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      keep_writes++;
   endtask

   function automatic key_field_type any_key();
      return key_field_type'({$urandom(), $urandom()});
   endfunction

   initial begin
      int unsigned   keep_plan[$];
      int            phase;
      int            bursts;
      int            n_offers;
      int            style;
      int            roll;
      int            waited;
      bit            quiet;
      count_type     cnt;

      keep_plan = '{63, 4, 33, 0, 16, 1, 31, 2, 8, 48};

      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.cmd         = CMD_OFFER;
      req_chan.entry_key   = '0;
      req_chan.entry_count = '0;
      csr_we               = 1'b0;
      csr_wdata            = '0;
      send_gaps            = 1'b0;
      rsp_stalls           = 1'b0;
      rsp_hold_len         = 0;
      requests_sent        = 0;
      drains_sent          = 0;
      keep_writes          = 0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---------------- directed ----------------
      // Field extremes, three-way tie on count 5, ignored command, drain order.
      write_keep(6'd32);
      push_request(CMD_OFFER, '0, '0);
      push_request(CMD_OFFER, '1, '1);
      push_request(CMD_OFFER, 48'h0000_0000_00A1, 32'd5);
      push_request(CMD_OFFER, 48'h0000_0000_00B2, 32'd5);
      push_request(CMD_OFFER, 48'h0000_0000_00C3, 32'd5);
      push_request(CMD_RESERVED, any_key(), $urandom());
      push_request(CMD_DRAIN, '0, '0);
      // Drain of an empty store produces nothing
      push_request(CMD_DRAIN, '1, '1);
      // Clear discards everything held
      push_request(CMD_OFFER, any_key(), 32'd77);
      push_request(CMD_OFFER, any_key(), 32'd78);
      push_request(CMD_CLEAR, any_key(), $urandom());
      push_request(CMD_DRAIN, '0, '0);
      wait_idle();

      // Single slot: equal count to the held minimum is dropped, larger replaces
      write_keep(6'd1);
      push_request(CMD_OFFER, 48'h0000_0000_0D00, 32'd7);
      push_request(CMD_OFFER, 48'h0000_0000_0E00, 32'd7);
      push_request(CMD_OFFER, 48'h0000_0000_0F00, 32'd8);
      push_request(CMD_DRAIN, '0, '0);
      wait_idle();

      // keep_count of zero drops every offer
      write_keep(6'd0);
      push_request(CMD_OFFER, any_key(), 32'd100);
      push_request(CMD_DRAIN, '0, '0);
      wait_idle();

      // Limit lowered under the current fill: nothing dropped, only min replaced
      write_keep(6'd32);
      push_request(CMD_OFFER, any_key(), 32'd10);
      push_request(CMD_OFFER, any_key(), 32'd20);
      push_request(CMD_OFFER, any_key(), 32'd30);
      push_request(CMD_OFFER, any_key(), 32'd40);
      wait_idle();
      write_keep(6'd2);
      push_request(CMD_OFFER, any_key(), 32'd25);
      push_request(CMD_OFFER, any_key(), 32'd5);
      push_request(CMD_DRAIN, '0, '0);

      // ---------------- random phases ----------------
      // Each phase: new keep_count, then bursts of offers closed by a drain most
      // of the time. A skipped drain leaves entries behind, so the next limit
      // often lands below the fill. Count styles mix dense ties with the full range.
      phase = 0;
      while (requests_sent < 24 + RANDOM_ITEMS) begin
         wait_idle();
         if (phase < keep_plan.size()) write_keep(cfg_type'(keep_plan[phase]));
         else write_keep(cfg_type'($urandom_range(0, 63)));

         quiet      = (requests_sent + 40 >= 24 + RANDOM_ITEMS);
         send_gaps  = !quiet && ($urandom_range(0, 3) != 0);
         rsp_stalls = !quiet && ($urandom_range(0, 3) != 0);
         bursts     = $urandom_range(1, 3);

         // Once: hold the response side long enough that a drain backs up and
         // the offers queued behind it stall at the request port.
         if (phase == 1) begin
            rsp_hold_len = LONG_HOLD;
            send_gaps    = 1'b0;
            bursts       = 2;
         end

         for (int b = 0; b < bursts; b++) begin
            n_offers = $urandom_range(3, 40);
            style    = $urandom_range(0, 3);
            for (int i = 0; i < n_offers && requests_sent < 24 + RANDOM_ITEMS; i++) begin
               // last stretch of the run streams with no idling on either side
               if (requests_sent + 40 >= 24 + RANDOM_ITEMS) begin
                  send_gaps  = 1'b0;
                  rsp_stalls = 1'b0;
               end
               roll = $urandom_range(0, 39);
               case (style)
                  0:       cnt = count_type'($urandom_range(0, 7));
                  1:       cnt = count_type'($urandom());
                  2:       cnt = 32'hFFFF_FFFF - count_type'($urandom_range(0, 3));
                  default: cnt = count_type'($urandom_range(0, 1000));
               endcase
               if (roll == 0) push_request(CMD_RESERVED, any_key(), cnt);
               else if (roll == 1) push_request(CMD_CLEAR, any_key(), cnt);
               else push_request(CMD_OFFER, any_key(), cnt);
            end
            if ((phase == 1 && b == 0) || $urandom_range(0, 3) != 0)
               push_request(CMD_DRAIN, any_key(), count_type'($urandom()));
         end
         phase++;
      end

      // Flush whatever is still held so the tail produces results too
      send_gaps  = 1'b0;
      rsp_stalls = 1'b0;
      push_request(CMD_DRAIN, any_key(), count_type'($urandom()));
      req_chan.valid <= 1'b0;

      waited = 0;
      while (chk_pending != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(negedge clock);

      if (chk_pending != 0)
         $display("%0d expected entries never came out", chk_pending);
      $display("covered %0d requests (%0d drains) across %0d keep_count settings",
               requests_sent, drains_sent, keep_writes);
      $display("checked %0d drained entries, %0d failures", chk_results, chk_errors);
      if (chk_errors == 0 && chk_pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
